[src/logistic_pulse_template_generator_defines.svh]
// Assertion macros for the logistic pulse template generator.
// Used by the top level only; no other dependencies.
`ifndef LOGISTIC_PULSE_TEMPLATE_GENERATOR_DEFINES_SVH
`define LOGISTIC_PULSE_TEMPLATE_GENERATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define LPTG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LPTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPTG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPTG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/lptg_pkg.sv]
// Shared constants, types and tables of the logistic pulse template generator.
// No dependencies.
package lptg_pkg;

  localparam int EXP_FRAC_BITS = 16;
  localparam int Z_CAP = 40;

  // z = |dt| * 2^F / tc, only needed below Z_CAP * 2^F
  localparam int ZQ_BITS = EXP_FRAC_BITS + 6;
  localparam int ZQ_STEPS = 4;
  localparam int ZQ_STG = (ZQ_BITS + ZQ_STEPS - 1) / ZQ_STEPS;

  // m = z in Q32, below 2^38
  localparam int M_BITS = ZQ_BITS + 32 - EXP_FRAC_BITS;
  localparam int K_BITS = 6;
  localparam int K_STEPS = 3;
  localparam int K_STG = K_BITS / K_STEPS;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam int HORNER_TERMS = 13;

  localparam int RC_BITS = 32;
  localparam int RC_STEPS = 4;
  localparam int RC_STG = RC_BITS / RC_STEPS;

  localparam int S_DROP = (EXP_FRAC_BITS < 31) ? 31 - EXP_FRAC_BITS : 0;
  localparam logic [31:0] S_MASK = ~((32'd1 << S_DROP) - 32'd1);

  localparam int LANE_LAT = ZQ_STG + K_STG + 2 * HORNER_TERMS + 1 + RC_STG + 1;
  // input stage, lanes, product, amplitude, sum
  localparam int PIPE_STG = LANE_LAT + 4;

  typedef enum logic [2:0] {
    CFG_AMPLITUDE  = 3'd0,
    CFG_DELAY_TIME = 3'd1,
    CFG_RISE_CONST = 3'd2,
    CFG_FALL_CONST = 3'd3,
    CFG_BASELINE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] mag;
    logic        neg;
    logic [15:0] tc;
  } lane_in_t;

  // floor(2^33 / n) for the Horner divide by n
  function automatic logic [33:0] recip_m(input logic [3:0] n);
    logic [33:0] m;
    m = '0;
    unique case (n)
      4'd1:    m = 34'd8589934592;
      4'd2:    m = 34'd4294967296;
      4'd3:    m = 34'd2863311530;
      4'd4:    m = 34'd2147483648;
      4'd5:    m = 34'd1717986918;
      4'd6:    m = 34'd1431655765;
      4'd7:    m = 34'd1227133513;
      4'd8:    m = 34'd1073741824;
      4'd9:    m = 34'd954437176;
      4'd10:   m = 34'd858993459;
      4'd11:   m = 34'd780903144;
      4'd12:   m = 34'd715827882;
      4'd13:   m = 34'd660764199;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[src/lptg_logistic.sv]
// One logistic edge: z divider, ln2 reduction, Horner exp series, reciprocal divider.
// Depends on lptg_pkg.
module lptg_logistic (
  input  logic              clk,
  input  logic              en,
  input  lptg_pkg::lane_in_t lane_in,
  output logic [31:0]       s_out
);
  import lptg_pkg::*;

  typedef struct packed {
    logic [31:0] r;
    logic [5:0]  k;
    logic        zero;
    logic        neg;
  } hside_t;

  // z divider
  logic [15:0]        zrem_r [ZQ_STG];
  logic [ZQ_BITS-1:0] zqd_r  [ZQ_STG];
  logic [15:0]        ztc_r  [ZQ_STG];
  logic               zcap_r [ZQ_STG];
  logic               zneg_r [ZQ_STG];

  for (genvar g = 0; g < ZQ_STG; g++) begin : g_zq
    logic [15:0]        rem_i, rem_o, tc_i;
    logic [ZQ_BITS-1:0] qd_i, qd_o;
    logic               cap_i, neg_i;
    if (g == 0) begin : g_src
      assign rem_i = 16'(lane_in.mag >> 6);
      assign qd_i  = ZQ_BITS'({lane_in.mag[5:0], {EXP_FRAC_BITS{1'b0}}});
      assign tc_i  = lane_in.tc;
      assign cap_i = {2'b0, lane_in.mag} >= (22'(lane_in.tc) * 22'(Z_CAP));
      assign neg_i = lane_in.neg;
    end else begin : g_chain
      assign rem_i = zrem_r[g-1];
      assign qd_i  = zqd_r[g-1];
      assign tc_i  = ztc_r[g-1];
      assign cap_i = zcap_r[g-1];
      assign neg_i = zneg_r[g-1];
    end
    always_comb begin
      logic [16:0] t;
      t = '0;
      rem_o = rem_i;
      qd_o = qd_i;
      for (int j = 0; j < ZQ_STEPS; j++) begin
        if (g * ZQ_STEPS + j < ZQ_BITS) begin
          t = {rem_o, qd_o[ZQ_BITS-1]};
          qd_o = {qd_o[ZQ_BITS-2:0], 1'b0};
          if (t >= {1'b0, tc_i}) begin
            t = t - {1'b0, tc_i};
            qd_o[0] = 1'b1;
          end
          rem_o = t[15:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zrem_r[g] <= rem_o;
        zqd_r[g]  <= qd_o;
        ztc_r[g]  <= tc_i;
        zcap_r[g] <= cap_i;
        zneg_r[g] <= neg_i;
      end
    end
  end

  // k = floor(m / ln2), r = m - k * ln2
  logic [M_BITS-1:0] kr_r   [K_STG];
  logic [K_BITS-1:0] kk_r   [K_STG];
  logic              kcap_r [K_STG];
  logic              kneg_r [K_STG];

  for (genvar h = 0; h < K_STG; h++) begin : g_k
    logic [M_BITS-1:0] rem_i, rem_o;
    logic [K_BITS-1:0] k_i, k_o;
    logic              cap_i, neg_i;
    if (h == 0) begin : g_src
      assign rem_i = M_BITS'(zqd_r[ZQ_STG-1]) << (32 - EXP_FRAC_BITS);
      assign k_i   = '0;
      assign cap_i = zcap_r[ZQ_STG-1];
      assign neg_i = zneg_r[ZQ_STG-1];
    end else begin : g_chain
      assign rem_i = kr_r[h-1];
      assign k_i   = kk_r[h-1];
      assign cap_i = kcap_r[h-1];
      assign neg_i = kneg_r[h-1];
    end
    always_comb begin
      logic [M_BITS-1:0] lv;
      int                b;
      lv = '0;
      b = 0;
      rem_o = rem_i;
      k_o = k_i;
      for (int j = 0; j < K_STEPS; j++) begin
        b = K_BITS - 1 - (h * K_STEPS + j);
        lv = M_BITS'(LN2_Q32) << b;
        if (rem_o >= lv) begin
          rem_o = rem_o - lv;
          k_o[b] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        kr_r[h]   <= rem_o;
        kk_r[h]   <= k_o;
        kcap_r[h] <= cap_i;
        kneg_r[h] <= neg_i;
      end
    end
  end

  // exp(-r) by Horner, two stages per term
  hside_t      ha_side_r [HORNER_TERMS];
  hside_t      hb_side_r [HORNER_TERMS];
  logic [31:0] hx_r      [HORNER_TERMS];
  logic [32:0] hacc_r    [HORNER_TERMS];

  for (genvar t = 0; t < HORNER_TERMS; t++) begin : g_horner
    localparam logic [3:0] N = 4'(HORNER_TERMS - t);
    hside_t      side_i;
    logic [32:0] acc_i;
    logic [64:0] prod;
    logic [65:0] y;
    logic [31:0] q0, q;
    logic [35:0] rem;
    if (t == 0) begin : g_src
      assign acc_i = 33'h1_0000_0000;
      assign side_i.r = kr_r[K_STG-1][31:0];
      assign side_i.k = kk_r[K_STG-1];
      assign side_i.zero = kcap_r[K_STG-1] || (kk_r[K_STG-1] >= K_BITS'(Z_CAP));
      assign side_i.neg = kneg_r[K_STG-1];
    end else begin : g_chain
      assign acc_i  = hacc_r[t-1];
      assign side_i = hb_side_r[t-1];
    end
    assign prod = 65'(side_i.r) * 65'(acc_i);
    assign y    = 66'(hx_r[t]) * 66'(recip_m(N));
    assign q0   = y[64:33];
    assign rem  = 36'(hx_r[t]) - 36'(q0) * 36'(N);
    assign q    = (rem >= 36'(N)) ? q0 + 32'd1 : q0;
    always_ff @(posedge clk) begin
      if (en) begin
        hx_r[t]      <= prod[63:32];
        ha_side_r[t] <= side_i;
        hacc_r[t]    <= 33'h1_0000_0000 - 33'(q);
        hb_side_r[t] <= ha_side_r[t];
      end
    end
  end

  // den = 1 + exp(-|z|), dividend 2^63 + den / 2
  logic [33:0] dden_r;
  logic [33:0] drem_r;
  logic [31:0] dqd_r;
  logic        dneg_r;
  logic [32:0] e_val;
  logic [33:0] den;
  logic [63:0] num;

  assign e_val = hb_side_r[HORNER_TERMS-1].zero ? '0 :
                 hacc_r[HORNER_TERMS-1] >> hb_side_r[HORNER_TERMS-1].k;
  assign den   = 34'h1_0000_0000 + 34'(e_val);
  assign num   = 64'h8000_0000_0000_0000 + 64'(den >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      dden_r <= den;
      drem_r <= 34'(num[63:32]);
      dqd_r  <= num[31:0];
      dneg_r <= hb_side_r[HORNER_TERMS-1].neg;
    end
  end

  // reciprocal divider
  logic [33:0] rrem_r [RC_STG];
  logic [31:0] rqd_r  [RC_STG];
  logic [33:0] rden_r [RC_STG];
  logic        rneg_r [RC_STG];

  for (genvar g = 0; g < RC_STG; g++) begin : g_rc
    logic [33:0] rem_i, rem_o, den_i;
    logic [31:0] qd_i, qd_o;
    logic        neg_i;
    if (g == 0) begin : g_src
      assign rem_i = drem_r;
      assign qd_i  = dqd_r;
      assign den_i = dden_r;
      assign neg_i = dneg_r;
    end else begin : g_chain
      assign rem_i = rrem_r[g-1];
      assign qd_i  = rqd_r[g-1];
      assign den_i = rden_r[g-1];
      assign neg_i = rneg_r[g-1];
    end
    always_comb begin
      logic [34:0] t;
      t = '0;
      rem_o = rem_i;
      qd_o = qd_i;
      for (int j = 0; j < RC_STEPS; j++) begin
        t = {rem_o, qd_o[RC_BITS-1]};
        qd_o = {qd_o[RC_BITS-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t = t - {1'b0, den_i};
          qd_o[0] = 1'b1;
        end
        rem_o = t[33:0];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rrem_r[g] <= rem_o;
        rqd_r[g]  <= qd_o;
        rden_r[g] <= den_i;
        rneg_r[g] <= neg_i;
      end
    end
  end

  // clamp, mirror for negative z, drop unused fraction bits
  logic [31:0] s_clamp, s_sign, s_r;

  assign s_clamp = (rqd_r[RC_STG-1] > 32'h8000_0000) ? 32'h8000_0000 : rqd_r[RC_STG-1];
  assign s_sign  = rneg_r[RC_STG-1] ? 32'h8000_0000 - s_clamp : s_clamp;

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_sign & S_MASK;
    end
  end

  assign s_out = s_r;

endmodule

[src/logistic_pulse_template_generator.sv]
// Logistic pulse template generator: baseline + amplitude * rise edge * fall edge.
// Input stage, both logistic lanes, then product, amplitude and sum registers feed
// the output buffer. Throughput: one request per cycle; the pipeline stalls as a
// whole only when the two-entry output buffer is full. Reset (rst_n low, synchronous)
// clears valid bits, output buffer and registers (rise/fall constants 16, others 0).
`include "logistic_pulse_template_generator_defines.svh"
module logistic_pulse_template_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [19:0] sample_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [21:0] template_value
  output logic [0:0]  out_tuser,  // [0] saturated
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  import lptg_pkg::*;

  logic signed [16:0] amplitude_r;
  logic [19:0]        delay_time_r;
  logic [15:0]        rise_const_r;
  logic [15:0]        fall_const_r;
  logic signed [15:0] baseline_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r  <= '0;
      delay_time_r <= '0;
      rise_const_r <= 16'd16;
      fall_const_r <= 16'd16;
      baseline_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_AMPLITUDE:  amplitude_r  <= cfg_data[16:0];
        CFG_DELAY_TIME: delay_time_r <= cfg_data;
        CFG_RISE_CONST: rise_const_r <= cfg_data[15:0];
        CFG_FALL_CONST: fall_const_r <= cfg_data[15:0];
        CFG_BASELINE:   baseline_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic                en;
  logic [PIPE_STG-1:0] vld_r;
  logic                out_valid_r, skid_valid_r;

  assign en = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_STG-2:0], in_tvalid};
    end
  end

  // input stage: dt = t - delay
  logic [20:0] dt;
  logic        late;
  logic [19:0] mag;
  lane_in_t    rise_in_r, fall_in_r;

  assign dt   = {1'b0, in_tdata[19:0]} - {1'b0, delay_time_r};
  assign late = !dt[20];
  assign mag  = late ? dt[19:0] : 20'(-dt);

  always_ff @(posedge clk) begin
    if (en) begin
      rise_in_r.mag <= mag;
      rise_in_r.neg <= !late;
      rise_in_r.tc  <= (rise_const_r == '0) ? 16'd1 : rise_const_r;
      fall_in_r.mag <= mag;
      fall_in_r.neg <= late && (mag != '0);
      fall_in_r.tc  <= (fall_const_r == '0) ? 16'd1 : fall_const_r;
    end
  end

  logic [31:0] s_rise, s_fall;

  lptg_logistic u_rise (
    .clk     (clk),
    .en      (en),
    .lane_in (rise_in_r),
    .s_out   (s_rise)
  );

  lptg_logistic u_fall (
    .clk     (clk),
    .en      (en),
    .lane_in (fall_in_r),
    .s_out   (s_fall)
  );

  // product, amplitude scaling, sum and clip
  logic [63:0]        sp;
  logic [31:0]        p_r;
  logic [16:0]        amag;
  logic [49:0]        ap;
  logic [21:0]        q_r;
  logic               qneg_r;
  logic signed [23:0] pulse, sum;
  logic [21:0]        tv_r;
  logic               sat_r;
  logic [21:0]        tv_nxt;
  logic               sat_nxt;

  assign sp   = 64'(s_rise) * 64'(s_fall);
  assign amag = amplitude_r[16] ? 17'(-amplitude_r) : amplitude_r;
  assign ap   = 50'(amag) * 50'(p_r) + 50'(1 << 26);

  assign pulse = qneg_r ? -24'(q_r) : 24'(q_r);
  assign sum   = pulse + 24'(baseline_r <<< 4);

  always_comb begin
    sat_nxt = 1'b0;
    tv_nxt  = sum[21:0];
    priority if (sum > 24'sd2097151) begin
      tv_nxt  = 22'h1F_FFFF;
      sat_nxt = 1'b1;
    end else if (sum < -24'sd2097152) begin
      tv_nxt  = 22'h20_0000;
      sat_nxt = 1'b1;
    end else begin
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= sp[62:31];
      q_r    <= ap[48:27];
      qneg_r <= amplitude_r[16];
      tv_r   <= tv_nxt;
      sat_r  <= sat_nxt;
    end
  end

  // two-entry output buffer
  logic        push, pop;
  logic [21:0] out_tv_r, skid_tv_r;
  logic        out_sat_r, skid_sat_r;

  assign push = en && vld_r[PIPE_STG-1];
  assign pop  = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_tv_r  <= skid_tv_r;
      out_sat_r <= skid_sat_r;
    end else if (push && (pop || !out_valid_r)) begin
      out_tv_r  <= tv_r;
      out_sat_r <= sat_r;
    end
    if (push && out_valid_r && !pop) begin
      skid_tv_r  <= tv_r;
      skid_sat_r <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tv_r};
  assign out_tuser  = out_sat_r;

  `LPTG_ASSERT_IMPL(a_skid_has_out, clk, rst_n, skid_valid_r, out_valid_r)
  `LPTG_ASSERT_NEXT(a_skid_held, clk, rst_n, skid_valid_r && !out_tready, skid_valid_r && out_valid_r)
  `LPTG_ASSERT_IMPL(a_never_clipped, clk, rst_n, out_valid_r, !out_sat_r)

endmodule

[tb/tb_logistic_pulse_template_generator.sv]
// Testbench for the logistic pulse template generator: directed and random sample times
// over several register settings, checked against a bit-true fixed-point predictor.
// Depends on lptg_pkg and the logistic_pulse_template_generator RTL.
`timescale 1ns / 1ps

module tb_logistic_pulse_template_generator;
  import lptg_pkg::*;

  localparam logic [2:0] CFG_IDX_UNUSED = 3'd5;
  localparam logic [2:0] CFG_IDX_LAST = 3'd7;
  localparam longint unsigned ONE_Q32 = 64'd1 << 32;
  localparam longint unsigned ONE_Q31 = 64'd1 << 31;
  localparam longint unsigned LN2_Q = 64'd2977044472;
  localparam int DRAIN_CYCLES = PIPE_STG + 10;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [21:0] value;
    logic        sat;
  } tmpl_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  logic signed [16:0] amp_reg;
  logic [19:0]        delay_reg;
  logic [15:0]        rise_reg;
  logic [15:0]        fall_reg;
  logic signed [15:0] base_reg;

  tmpl_t expected_q[$];
  int    n_err = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_sat = 0;
  int    n_cfg = 0;
  int    cycles = 0;
  bit    quiet = 0;

  logistic_pulse_template_generator i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned exp_neg_q32(longint unsigned m);
    longint unsigned k, r, acc;
    k = m / LN2_Q;
    r = m - k * LN2_Q;
    acc = ONE_Q32;
    if (k >= 40) return 0;
    for (int n = 13; n >= 1; n--) acc = ONE_Q32 - ((r * acc) >> 32) / n;
    return acc >> k;
  endfunction

  function automatic longint unsigned sigmoid_q31(bit neg, longint unsigned mag,
                                                  longint unsigned tc);
    longint unsigned zq, e, den, s;
    if (tc == 0) tc = 1;
    zq = (mag << EXP_FRAC_BITS) / tc;
    e = (zq >= (longint'(Z_CAP) << EXP_FRAC_BITS)) ? 0 :
        exp_neg_q32(zq << (32 - EXP_FRAC_BITS));
    den = ONE_Q32 + e;
    s = ((64'd1 << 63) + den / 2) / den;
    if (s > ONE_Q31) s = ONE_Q31;
    if (neg) s = ONE_Q31 - s;
    s &= ~((64'd1 << S_DROP) - 1);
    return s;
  endfunction

  function automatic tmpl_t pulse_at(logic [19:0] t);
    longint dt, pulse, sum;
    longint unsigned mag, sr, sf, p, amag, q;
    bit late;
    tmpl_t res;
    dt = longint'(t) - longint'(delay_reg);
    late = dt >= 0;
    mag = late ? dt : -dt;
    sr = sigmoid_q31(!late, mag, rise_reg);
    sf = sigmoid_q31(late && mag != 0, mag, fall_reg);
    p = (sr * sf) >> 31;
    amag = amp_reg < 0 ? -longint'(amp_reg) : longint'(amp_reg);
    q = (amag * p + (64'd1 << 26)) >> 27;
    pulse = amp_reg < 0 ? -longint'(q) : longint'(q);
    sum = pulse + longint'(base_reg) * 16;
    res.sat = 1'b0;
    if (sum > 2097151) begin
      sum = 2097151;
      res.sat = 1'b1;
    end else if (sum < -2097152) begin
      sum = -2097152;
      res.sat = 1'b1;
    end
    res.value = sum[21:0];
    return res;
  endfunction

  task automatic report(string what, logic [21:0] got, logic [21:0] want);
    n_err++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, $signed(got),
             $signed(want), n_results);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    tmpl_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report("unexpected result", out_tdata[21:0], '0);
      end else begin
        want = expected_q.pop_front();
        if (out_tdata[21:0] !== want.value) report("template_value", out_tdata[21:0], want.value);
        if (out_tuser[0] !== want.sat) report("saturated", 22'(out_tuser[0]), 22'(want.sat));
        if (want.sat) n_sat++;
      end
    end
  end

  always @(negedge clk) out_tready <= quiet || ($urandom_range(99) >= 16);

  task automatic send_time(logic [19:0] t);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 16) begin
      in_tvalid = 1'b0;
      in_tdata = 24'($urandom);
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {4'd0, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(pulse_at(t));
    n_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_AMPLITUDE:  amp_reg = val[16:0];
      CFG_DELAY_TIME: delay_reg = val;
      CFG_RISE_CONST: rise_reg = val[15:0];
      CFG_FALL_CONST: fall_reg = val[15:0];
      CFG_BASELINE:   base_reg = val[15:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(logic signed [16:0] a, logic [19:0] d, logic [15:0] r,
                         logic [15:0] f, logic signed [15:0] b);
    wait_idle();
    write_reg(CFG_AMPLITUDE, 20'(unsigned'(a)));
    write_reg(CFG_DELAY_TIME, d);
    write_reg(CFG_RISE_CONST, 20'(r));
    write_reg(CFG_FALL_CONST, 20'(f));
    write_reg(CFG_BASELINE, 20'(unsigned'(b)));
  endtask

  function automatic logic [19:0] near_delay(int span);
    longint t;
    t = longint'(delay_reg) + $signed($urandom_range(2 * span)) - span;
    if (t < 0) t = 0;
    if (t > 20'hFFFFF) t = 20'hFFFFF;
    return t[19:0];
  endfunction

  task automatic test_reset_values();
    // zero amplitude and baseline after reset
    send_time(20'd0);
    send_time(20'hFFFFF);
    send_time(20'd16);
  endtask

  task automatic test_extremes();
    logic [19:0] pts [7];
    pts = '{20'd0, 20'd480, 20'd511, 20'd512, 20'd513, 20'd600, 20'hFFFFF};
    set_all(17'sd65535, 20'd512, 16'd16, 16'd64, 16'sd0);
    foreach (pts[i]) send_time(pts[i]);
    // zero time constants act as one
    set_all(-17'sd65536, 20'hFFFFF, 16'd0, 16'd0, 16'sd32767);
    send_time(20'hFFFFF);
    send_time(20'hFFFFE);
    send_time(20'd0);
    set_all(-17'sd65536, 20'd0, 16'd65535, 16'd65535, -16'sd32768);
    send_time(20'd0);
    send_time(20'd1);
    send_time(20'hFFFFF);
    set_all(17'sd65535, 20'd1000, 16'd1, 16'd65535, 16'sd32767);
    send_time(20'd1000);
    send_time(20'd999);
    send_time(20'd70000);
  endtask

  task automatic test_unused_index();
    wait_idle();
    write_reg(CFG_IDX_UNUSED, 20'hFFFFF);
    write_reg(CFG_IDX_LAST, 20'h12345);
    send_time(20'd1000);
    send_time(20'd1200);
  endtask

  task automatic test_random();
    logic [15:0] tc;
    for (int phase = 0; phase < 10; phase++) begin
      tc = (phase % 3 == 0) ? 16'($urandom_range(1, 64)) : 16'($urandom_range(0, 65535));
      set_all(17'($urandom), 20'($urandom), tc, 16'($urandom_range(0, 2000)), 16'($urandom));
      quiet = (phase == 4);
      for (int i = 0; i < 110; i++) begin
        if (phase == 6 && i == 55) wait_idle();
        if ($urandom_range(3) == 0) send_time(20'($urandom));
        else send_time(near_delay(8 * (rise_reg + fall_reg) + 4));
      end
      quiet = 0;
    end
  endtask

  initial begin
    amp_reg = '0;
    delay_reg = '0;
    rise_reg = 16'd16;
    fall_reg = 16'd16;
    base_reg = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_extremes();
    test_unused_index();
    test_random();
    wait_idle();
    $display("sent %0d sample times, checked %0d template values (%0d clipped)",
             n_items, n_results, n_sat);
    $display("%0d register writes across directed extremes and ten random settings", n_cfg);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
